@@ hdl/hkwd_pkg.sv @@
// ----------------------------------------------------------------------------
// hkwd_pkg
// Shared types, constants and hash helpers for the keystream word decoder.
// ----------------------------------------------------------------------------
package hkwd_pkg;

	// Field widths
	localparam int WORD_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int HASH_W   = 28;
	localparam int SUM_W    = 32;
	localparam int FOLD_W   = 16;
	localparam int DIGITS   = 8;
	localparam int NIBBLE_W = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [FOLD_W-1:0] fold_t;
	typedef logic [NIBBLE_W-1:0] nibble_t;

	// ASCII offsets for lowercase hex digits
	localparam byte_t ASCII_ZERO  = 8'h30;
	localparam byte_t ASCII_A_M10 = 8'h57; // 'a' minus ten
	localparam nibble_t DEC_LIMIT = 4'd10;

	// Nibble to lowercase ASCII hex character
	function automatic byte_t hex_char(input nibble_t nib);
		byte_t ext;
		ext = {4'b0000, nib};
		return (nib < DEC_LIMIT) ? byte_t'(ASCII_ZERO + ext) : byte_t'(ASCII_A_M10 + ext);
	endfunction

	// One ELF hash step. The state never leaves 28 bits: the top nibble of
	// the shifted sum folds back into bits 7:4 and is then cleared.
	function automatic hash_t elf_step(input hash_t h, input byte_t ch);
		sum_t  t;
		logic [3:0] top;
		t   = sum_t'({h, 4'b0000}) + sum_t'(ch);
		top = t[SUM_W-1:HASH_W];
		return t[HASH_W-1:0] ^ hash_t'({top, 4'b0000});
	endfunction

endpackage

@@ hdl/hkwd_word_if.sv @@
// ----------------------------------------------------------------------------
// hkwd_word_if
// Valid/ready channel carrying one encoded 16-bit word per transfer.
// ----------------------------------------------------------------------------
interface hkwd_word_if;
	logic            valid;
	logic            ready;
	hkwd_pkg::word_t encoded_word;

	modport source (output valid, output encoded_word, input ready);
	modport sink   (input valid, input encoded_word, output ready);
endinterface

@@ hdl/hkwd_byte_if.sv @@
// ----------------------------------------------------------------------------
// hkwd_byte_if
// Valid/ready channel carrying one decoded byte per transfer.
// ----------------------------------------------------------------------------
interface hkwd_byte_if;
	logic            valid;
	logic            ready;
	hkwd_pkg::byte_t plain_byte;

	modport source (output valid, output plain_byte, input ready);
	modport sink   (input valid, input plain_byte, output ready);
endinterface

@@ hdl/hkwd_hash.sv @@
// ----------------------------------------------------------------------------
// hkwd_hash
// Hashes the running sum as eight hex characters from the seed state and
// folds the result to 16 bits.
// ----------------------------------------------------------------------------
module hkwd_hash (
	input  hkwd_pkg::hash_t seed,
	input  hkwd_pkg::sum_t  sum,
	output hkwd_pkg::fold_t fold
);

	hkwd_pkg::hash_t h;
	logic [hkwd_pkg::FOLD_W:0] half_sum;

	// Eight ELF steps, most significant digit first
	always_comb begin
		h = seed;
		for (int i = 0; i < hkwd_pkg::DIGITS; i++) begin
			h = hkwd_pkg::elf_step(h, hkwd_pkg::hex_char(
				sum[(hkwd_pkg::DIGITS-1-i)*hkwd_pkg::NIBBLE_W +: hkwd_pkg::NIBBLE_W]));
		end
	end

	// Fold: (high half + low half) / 2
	assign half_sum = (hkwd_pkg::FOLD_W+1)'(h[hkwd_pkg::HASH_W-1:hkwd_pkg::FOLD_W])
		+ (hkwd_pkg::FOLD_W+1)'(h[hkwd_pkg::FOLD_W-1:0]);
	assign fold = half_sum[hkwd_pkg::FOLD_W:1];

endmodule

@@ hdl/hash_keystream_word_decoder.sv @@
// ----------------------------------------------------------------------------
// hash_keystream_word_decoder
// Decodes one byte per encoded word using an ELF hash of the running sum.
// ----------------------------------------------------------------------------
//  channel    dir  payload                  transfer when
//  word_ch    in   encoded_word [15:0]      valid && ready
//  byte_ch    out  plain_byte   [7:0]       valid && ready
//  cfg        in   cfg_wdata    [27:0]      cfg_we (seed register)
//
//  One word per cycle while the result register is free; a word passes the
//  input register and then the result register, and an output stall holds it.
//  The hash and fold sit between the input register and the result register;
//  the running sum updates as the result register loads, so the next word
//  sees it in the following cycle.
//  Reset clears the sum, the seed and both valid flags.
//  A stalled result holds; the input register keeps taking words as the
//  result register drains.
// ----------------------------------------------------------------------------
module hash_keystream_word_decoder (
	input  logic                clk,
	input  logic                arst_n,
	hkwd_word_if.sink           word_ch,
	hkwd_byte_if.source         byte_ch,
	input  logic                cfg_we,
	input  hkwd_pkg::hash_t     cfg_wdata
);

	hkwd_pkg::hash_t seed_q;
	hkwd_pkg::sum_t  sum_q;
	hkwd_pkg::word_t word_s1;
	logic            valid_s1;
	hkwd_pkg::byte_t plain_q;
	logic            valid_q;

	hkwd_pkg::fold_t fold;
	hkwd_pkg::byte_t plain_nxt;
	logic            out_free;
	logic            advance;
	logic            in_xfer;

	// Handshake
	assign out_free      = !valid_q || byte_ch.ready;
	assign advance       = valid_s1 && out_free;
	assign word_ch.ready = !valid_s1 || out_free;
	assign in_xfer       = word_ch.valid && word_ch.ready;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ch.ready) begin
			valid_s1 <= word_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			word_s1 <= word_ch.encoded_word;
		end
	end

	// Hash of the current sum
	hkwd_hash u_hash (
		.seed (seed_q),
		.sum  (sum_q),
		.fold (fold)
	);

	assign plain_nxt = word_s1[hkwd_pkg::BYTE_W-1:0] - fold[hkwd_pkg::BYTE_W-1:0];

	// Result register and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sum_q   <= '0;
		end else begin
			if (out_free) begin
				valid_q <= valid_s1;
			end
			if (advance) begin
				sum_q <= sum_q + hkwd_pkg::sum_t'(plain_nxt);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			plain_q <= plain_nxt;
		end
	end

	assign byte_ch.valid      = valid_q;
	assign byte_ch.plain_byte = plain_q;

endmodule

@@ hdl/hkwd_checker.sv @@
// ----------------------------------------------------------------------------
// hkwd_checker
// Port-level checks for the keystream word decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hkwd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input hkwd_pkg::byte_t plain_byte
);

	// Stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plain_byte))
		else $error("result changed while stalled");

	// Every accepted word is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing two cycles after word transfer");

	// A result only appears after a word transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching word");

endmodule

bind hash_keystream_word_decoder hkwd_checker u_hkwd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (word_ch.valid),
	.in_ready   (word_ch.ready),
	.out_valid  (byte_ch.valid),
	.out_ready  (byte_ch.ready),
	.plain_byte (byte_ch.plain_byte)
);

@@ dv/hkwd_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hkwd_scoreboard_pkg
// Byte predictor and in-order checker for the keystream word decoder. The
// predictor mirrors the ELF hash of the running sum's hex text and the fold.
// ----------------------------------------------------------------------------
package hkwd_scoreboard_pkg;

	localparam logic [31:0] HASH_TOP     = 32'hF000_0000;
	localparam int          TOP_SHIFT    = 24;
	localparam logic [31:0] CHAR_ZERO    = 32'h30;
	localparam logic [31:0] CHAR_LOWER_A = 32'h61;
	localparam int          MAX_REPORTS  = 10;

	class hkwd_scoreboard;
		hkwd_pkg::hash_t seed;
		hkwd_pkg::sum_t  sum;
		hkwd_pkg::byte_t expected_bytes[$];
		int              errors;
		int              reported;

		function new();
			seed     = '0;
			sum      = '0;
			errors   = 0;
			reported = 0;
		endfunction

		function void set_seed(hkwd_pkg::hash_t v);
			seed = v;
		endfunction

		// Hash the current sum as eight lowercase hex chars, MSB first, then fold
		function hkwd_pkg::fold_t sum_fold();
			logic [31:0]       h;
			logic [31:0]       top;
			logic [31:0]       ch;
			hkwd_pkg::nibble_t nib;
			h = {4'b0000, seed};
			for (int i = hkwd_pkg::DIGITS - 1; i >= 0; i--) begin
				nib = sum[i*hkwd_pkg::NIBBLE_W +: hkwd_pkg::NIBBLE_W];
				ch  = (nib < 4'd10) ? (CHAR_ZERO + nib) : (CHAR_LOWER_A + nib - 32'd10);
				h   = (h << 4) + ch;
				top = h & HASH_TOP;
				h   = (h ^ (top >> TOP_SHIFT)) & ~top;
			end
			return hkwd_pkg::fold_t'(({1'b0, h[31:16]} + {1'b0, h[15:0]}) >> 1);
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (reported < MAX_REPORTS) begin
				reported++;
				$display("%0t: %s", $time, msg);
			end
		endfunction

		// Accepted word: predict its byte and advance the sum
		function void note_word(hkwd_pkg::word_t w);
			hkwd_pkg::fold_t f;
			hkwd_pkg::byte_t p;
			f = sum_fold();
			p = w[7:0] - f[7:0];
			expected_bytes.push_back(p);
			sum = sum + hkwd_pkg::sum_t'(p);
		endfunction

		// Accepted byte: compare with the oldest prediction
		function void check_byte(hkwd_pkg::byte_t got);
			hkwd_pkg::byte_t want;
			if (expected_bytes.size() == 0) begin
				flag($sformatf("unexpected plain_byte %02h, nothing pending", got));
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want)
					flag($sformatf("plain_byte mismatch: expected %02h, got %02h", want, got));
			end
		endfunction

		function void check_drained();
			while (expected_bytes.size() != 0)
				flag($sformatf("plain_byte %02h never arrived", expected_bytes.pop_front()));
		endfunction
	endclass

endpackage

@@ dv/tb_hash_keystream_word_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_keystream_word_decoder
// Drives encoded words under random sender gaps and receiver stalls, loads
// several seeds including both extremes, and checks every decoded byte in
// order against a predictor of the running-sum ELF hash keystream.
// ----------------------------------------------------------------------------
module tb_hash_keystream_word_decoder;

	localparam int              PHASE_WORDS = 480;
	localparam hkwd_pkg::hash_t SEED_MAX    = '1;
	localparam hkwd_pkg::hash_t SEED_MIN    = '0;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	hkwd_pkg::hash_t cfg_wdata;
	int              tx_idle_pct = 22;
	int              rx_idle_pct = 52;

	hkwd_scoreboard_pkg::hkwd_scoreboard sb;

	hkwd_word_if word_ch ();
	hkwd_byte_if byte_ch ();

	hash_keystream_word_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.byte_ch   (byte_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#3ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver backpressure
	initial begin
		byte_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			byte_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Check each output transfer
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			sb.check_byte(byte_ch.plain_byte);
	end

	// Word whose decoded byte will be the given value
	function automatic hkwd_pkg::word_t craft_word(hkwd_pkg::byte_t target);
		hkwd_pkg::fold_t f;
		f = sb.sum_fold();
		return {hkwd_pkg::byte_t'($urandom), hkwd_pkg::byte_t'(target + f[7:0])};
	endfunction

	// Mostly random words; some steer the byte to its extremes
	function automatic hkwd_pkg::word_t pick_word();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return craft_word(8'hFF);
		else if (r < 35)
			return craft_word(8'h00);
		return hkwd_pkg::word_t'($urandom);
	endfunction

	task automatic send_word(hkwd_pkg::word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			word_ch.valid        <= 1'b0;
			word_ch.encoded_word <= hkwd_pkg::word_t'($urandom);
			@(posedge clk);
		end
		word_ch.valid        <= 1'b1;
		word_ch.encoded_word <= w;
		@(posedge clk);
		while (!word_ch.ready)
			@(posedge clk);
		sb.note_word(w);
	endtask

	// Hold off the sender until every byte is back
	task automatic drain();
		word_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_seed(hkwd_pkg::hash_t v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_seed(v);
	endtask

	task automatic run_random(int n);
		repeat (n) send_word(pick_word());
	endtask

	// Field extremes and bit patterns, then bytes forced to 00 and FF
	task automatic run_directed();
		hkwd_pkg::word_t fixed_words [16] = '{
			16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0001, 16'h8000,
			16'h5555, 16'hAAAA, 16'h7FFF, 16'h8001, 16'h0F0F, 16'hF0F0,
			16'h00FE, 16'h0100, 16'h1234, 16'hFEDC
		};
		foreach (fixed_words[i])
			send_word(fixed_words[i]);
		repeat (2) send_word(craft_word(8'h00));
		repeat (4) send_word(craft_word(8'hFF));
	endtask

	initial begin
		sb                   = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		word_ch.valid        = 1'b0;
		word_ch.encoded_word = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset seed, sender idles lightly, receiver stalls often
		run_directed();
		load_seed(SEED_MAX);
		run_random(PHASE_WORDS / 2);
		drain();
		run_random(PHASE_WORDS / 2);

		// Swapped idle rates
		tx_idle_pct = 52;
		rx_idle_pct = 22;
		load_seed(hkwd_pkg::hash_t'($urandom));
		run_random(PHASE_WORDS);

		// Full rate on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_seed(SEED_MIN);
		run_random(PHASE_WORDS / 2);
		load_seed(hkwd_pkg::hash_t'($urandom));
		run_random(PHASE_WORDS / 2);

		drain();
		repeat (6) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
